// ----- rtl/mhpq_pkg.sv -----
// mhpq_pkg: key and status types for the heap priority queue; the key type is
// shared with its entry store; no dependencies
package mhpq_pkg;

    localparam int KEY_W = 32;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

endpackage

// ----- rtl/mhpq_ram.sv -----
// mhpq_ram: heap entry store, one write port and two registered read ports
// depends on mhpq_pkg for the key type
module mhpq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic           clk,
    input  logic           we,
    input  logic [AW-1:0]  waddr,
    input  mhpq_pkg::key_t wdata,
    input  logic [AW-1:0]  raddr_a,
    input  logic [AW-1:0]  raddr_b,
    output mhpq_pkg::key_t rdata_a,
    output mhpq_pkg::key_t rdata_b
);
    import mhpq_pkg::*;

    key_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read ports, registered
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- rtl/max_heap_priority_queue.sv -----
// max_heap_priority_queue: binary max-heap of signed keys held in a synchronous store
// depends on mhpq_pkg and mhpq_ram
//
// Each input word asks to insert a key (tuser 0) or delete one occurrence of a key
// (tuser 1); one result word follows with a status, the element count and the
// current maximum. One request is worked on at a time. An insert places the key in
// the next free slot and sifts it up, a level at a time: read the parent, then
// compare and move. A delete first scans the held entries, one read a cycle, then
// moves the last entry into the hole and sifts it up or down a level at a time.
// Every step goes through the single read-modify-write path of the entry store.
// The store needs no clearing pass after reset: only entries below the count are
// read. A new request is taken while the previous result still waits.
module max_heap_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // request: tdata = key_value[31:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // request: tuser = func
    input  logic        s_tuser,
    // result: tdata = element_count[4:0], top_valid[5], top_key[37:6], zero pad[39:38]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    // result: tuser = status[1:0]
    output logic [1:0]  m_tuser
);
    import mhpq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_DEL_RD, S_DEL_LD, S_UP_RD, S_UP_CMP,
        S_DN_RD, S_DN_CMP, S_FIN, S_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   pos_reg, pos_next;
    key_t            val_reg, val_next;
    key_t            key_reg, key_next;
    logic            del_reg, del_next;
    logic            moved_reg, moved_next;
    logic [CW-1:0]   issue_reg, issue_next;
    logic [AW-1:0]   cmp_idx_reg, cmp_idx_next;
    logic            cmp_valid_reg, cmp_valid_next;
    status_t         status_reg, status_next;
    status_t         ostat_reg, ostat_next;
    logic [4:0]      ocount_reg, ocount_next;
    logic            otop_valid_reg, otop_valid_next;
    key_t            otop_key_reg, otop_key_next;
    logic            ovalid_reg, ovalid_next;

    logic            we;
    logic [AW-1:0]   waddr;
    key_t            wdata;
    logic [AW-1:0]   raddr_a, raddr_b;
    key_t            rdata_a, rdata_b;

    logic [IW-1:0]   left_idx, right_idx, count_ext;
    logic [AW-1:0]   parent_idx, last_idx;
    logic [CW+4:0]   count_wide;
    logic            right_ok;
    key_t            best_val;

    mhpq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // tree index arithmetic
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + IW'(1);
    assign count_ext  = IW'(count_reg);
    assign parent_idx = AW'((pos_reg - AW'(1)) >> 1);
    assign last_idx   = AW'(count_reg - CW'(1));
    assign right_ok   = right_idx < count_ext;
    assign best_val   = (rdata_a > val_reg) ? rdata_a : val_reg;
    assign count_wide = {5'b0, count_reg};

    // sequencer next state and store accesses
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        key_next        = key_reg;
        del_next        = del_reg;
        moved_next      = moved_reg;
        issue_next      = issue_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        status_next     = status_reg;
        ostat_next      = ostat_reg;
        ocount_next     = ocount_reg;
        otop_valid_next = otop_valid_reg;
        otop_key_next   = otop_key_reg;
        ovalid_next     = ovalid_reg & ~m_tready;
        we              = 1'b0;
        waddr           = pos_reg;
        wdata           = val_reg;
        raddr_a         = '0;
        raddr_b         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    key_next    = s_tdata;
                    val_next    = s_tdata;
                    del_next    = s_tuser;
                    moved_next  = 1'b0;
                    status_next = ST_OK;
                    if (s_tuser)
                    begin
                        issue_next     = '0;
                        cmp_valid_next = 1'b0;
                        state_next     = S_SRCH;
                    end
                    else if (count_reg >= CAP)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        pos_next   = AW'(count_reg);
                        count_next = count_reg + CW'(1);
                        state_next = S_UP_RD;
                    end
                end
            end

            // linear scan, the compare works on the previous read's registered data
            S_SRCH:
            begin
                if (cmp_valid_reg && rdata_a == key_reg)
                begin
                    pos_next       = cmp_idx_reg;
                    cmp_valid_next = 1'b0;
                    state_next     = S_DEL_RD;
                end
                else if (issue_reg < count_reg)
                begin
                    raddr_a        = AW'(issue_reg);
                    cmp_idx_next   = AW'(issue_reg);
                    cmp_valid_next = 1'b1;
                    issue_next     = issue_reg + CW'(1);
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                    if (!cmp_valid_reg)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_FIN;
                    end
                end
            end

            // fetch the last entry to fill the hole
            S_DEL_RD:
            begin
                raddr_a    = last_idx;
                state_next = S_DEL_LD;
            end

            S_DEL_LD:
            begin
                val_next   = rdata_a;
                count_next = count_reg - CW'(1);
                if (pos_reg == last_idx)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_UP_RD;
                end
            end

            // sift up: hole at pos, moving value held in val
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    if (del_reg && !moved_reg)
                    begin
                        state_next = S_DN_RD;
                    end
                    else
                    begin
                        we         = 1'b1;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    raddr_a    = parent_idx;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                if (val_reg > rdata_a)
                begin
                    we         = 1'b1;
                    wdata      = rdata_a;
                    pos_next   = parent_idx;
                    moved_next = 1'b1;
                    state_next = S_UP_RD;
                end
                else if (del_reg && !moved_reg)
                begin
                    state_next = S_DN_RD;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = S_FIN;
                end
            end

            // sift down: read both children together
            S_DN_RD:
            begin
                if (left_idx >= count_ext)
                begin
                    we         = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    raddr_a    = AW'(left_idx);
                    raddr_b    = right_ok ? AW'(right_idx) : AW'(left_idx);
                    state_next = S_DN_CMP;
                end
            end

            S_DN_CMP:
            begin
                if (right_ok && rdata_b > best_val)
                begin
                    we         = 1'b1;
                    wdata      = rdata_b;
                    pos_next   = AW'(right_idx);
                    state_next = S_DN_RD;
                end
                else if (rdata_a > val_reg)
                begin
                    we         = 1'b1;
                    wdata      = rdata_a;
                    pos_next   = AW'(left_idx);
                    state_next = S_DN_RD;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = S_FIN;
                end
            end

            // read back the root for the result
            S_FIN:
            begin
                raddr_a    = '0;
                state_next = S_OUT;
            end

            // load the result word once the output register is free
            S_OUT:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ostat_next      = status_reg;
                    ocount_next     = count_wide[4:0];
                    otop_valid_next = (count_reg != '0);
                    otop_key_next   = (count_reg != '0) ? rdata_a : key_t'(0);
                    ovalid_next     = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pos_reg        <= '0;
            val_reg        <= '0;
            key_reg        <= '0;
            del_reg        <= 1'b0;
            moved_reg      <= 1'b0;
            issue_reg      <= '0;
            cmp_idx_reg    <= '0;
            cmp_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            ostat_reg      <= ST_OK;
            ocount_reg     <= '0;
            otop_valid_reg <= 1'b0;
            otop_key_reg   <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            val_reg        <= val_next;
            key_reg        <= key_next;
            del_reg        <= del_next;
            moved_reg      <= moved_next;
            issue_reg      <= issue_next;
            cmp_idx_reg    <= cmp_idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            status_reg     <= status_next;
            ostat_reg      <= ostat_next;
            ocount_reg     <= ocount_next;
            otop_valid_reg <= otop_valid_next;
            otop_key_reg   <= otop_key_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    // stream ports
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tuser  = ostat_reg;
    assign m_tdata  = {2'b00, otop_key_reg, otop_valid_reg, ocount_reg};

endmodule

// ----- test/max_heap_priority_queue_tb.sv -----
`timescale 1ns / 100ps
// max_heap_priority_queue_tb: self-checking bench for the heap priority queue
// drives insert and delete words, predicts status, count and maximum per word
// depends on mhpq_pkg and max_heap_priority_queue
module max_heap_priority_queue_tb;

    import mhpq_pkg::*;

    localparam int CAPACITY    = 16;
    localparam bit OP_INSERT   = 1'b0;
    localparam bit OP_DELETE   = 1'b1;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 60;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        status_t    status;
        logic [4:0] count;
        logic       top_valid;
        key_t       top_key;
    } heap_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    // predicted contents of the heap, order irrelevant
    key_t         heap_keys[$];
    heap_result_t pending_results[$];

    int cycle_count   = 0;
    int mismatches    = 0;
    int requests_sent = 0;
    int results_seen  = 0;
    int full_seen     = 0;
    int miss_seen     = 0;
    int burst_left    = 0;
    int hold_token    = 0;

    max_heap_priority_queue #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("max_heap_priority_queue_tb failed");
            $finish;
        end
    end

    // apply one request to the predicted heap and give the result it yields
    function automatic heap_result_t apply_to_heap(input bit func, input key_t key);
        heap_result_t r;
        int           hit;
        key_t         best;
        r.status = ST_OK;
        hit      = -1;
        if (func == OP_INSERT)
        begin
            if (heap_keys.size() >= CAPACITY)
                r.status = ST_FULL;
            else
                heap_keys.push_back(key);
        end
        else
        begin
            foreach (heap_keys[i])
                if (hit < 0 && heap_keys[i] == key)
                    hit = i;
            if (hit < 0)
                r.status = ST_NOT_FOUND;
            else
                heap_keys.delete(hit);
        end
        best = '0;
        foreach (heap_keys[i])
            if (i == 0 || heap_keys[i] > best)
                best = heap_keys[i];
        r.count     = 5'(heap_keys.size());
        r.top_valid = (heap_keys.size() != 0);
        r.top_key   = best;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // mixture of wide random keys, a narrow band for duplicates, the extremes and powers of two
    function automatic key_t pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return key_t'($urandom);
            4, 5, 6:    return key_t'(int'($urandom_range(0, 16)) - 8);
            7:          return key_t'(32'h8000_0000 + $urandom_range(0, 3));
            8:          return key_t'(32'h7fff_ffff - $urandom_range(0, 3));
            default:    return key_t'(32'h0000_0001 << $urandom_range(0, 31));
        endcase
    endfunction

    function automatic key_t pick_held_key();
        return heap_keys[$urandom_range(0, heap_keys.size() - 1)];
    endfunction

    // send one word, predict its result, then idle between bursts
    task automatic send_request(input bit func, input key_t key);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= key;
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(apply_to_heap(func, key));
        requests_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // sender goes quiet until every predicted result has arrived
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver: stall rate is redrawn whenever its countdown runs out, with long hold-offs on request
    always @(posedge clk)
    begin : rx_pattern
        int hold_seen;
        int hold_left;
        int stall_left;
        int stall_pct;
        if (rst_n)
        begin
            if (hold_seen != hold_token)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (stall_left == 0)
            begin
                case ($urandom_range(0, 5))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 10;
                    3:       stall_pct = 30;
                    4:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                stall_left = 64;
            end
            else
                stall_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin : result_check
        heap_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result word 0x%h with nothing expected", m_tdata));
            else
            begin
                want = pending_results.pop_front();
                if (want.status == ST_FULL)
                    full_seen++;
                if (want.status == ST_NOT_FOUND)
                    miss_seen++;
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_tuser, want.status));
                if (m_tdata[4:0] !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              m_tdata[4:0], want.count));
                if (m_tdata[5] !== want.top_valid)
                    report_mismatch($sformatf("top_valid %b, expected %b",
                                              m_tdata[5], want.top_valid));
                if (m_tdata[37:6] !== want.top_key)
                    report_mismatch($sformatf("top_key %0d, expected %0d",
                                              $signed(m_tdata[37:6]), want.top_key));
                if (m_tdata[39:38] !== 2'b00)
                    report_mismatch($sformatf("pad bits %b not zero", m_tdata[39:38]));
            end
        end
    end

    // deletes on an empty heap
    task automatic test_empty_delete();
        send_request(OP_DELETE, key_t'(0));
        send_request(OP_DELETE, key_t'(32'h8000_0000));
    endtask

    // extreme keys in and out, plus a miss on a non-empty heap
    task automatic test_extreme_keys();
        send_request(OP_INSERT, key_t'(32'h8000_0000));
        send_request(OP_INSERT, key_t'(32'h7fff_ffff));
        send_request(OP_INSERT, key_t'(0));
        send_request(OP_INSERT, key_t'(-1));
        send_request(OP_INSERT, key_t'(1));
        send_request(OP_DELETE, key_t'(32'h7fff_ffff));
        send_request(OP_DELETE, key_t'(5));
        send_request(OP_DELETE, key_t'(32'h8000_0000));
        send_request(OP_DELETE, key_t'(-1));
        send_request(OP_DELETE, key_t'(1));
        send_request(OP_DELETE, key_t'(0));
    endtask

    // duplicate keys, each delete takes one occurrence
    task automatic test_duplicates();
        send_request(OP_INSERT, key_t'(7));
        send_request(OP_INSERT, key_t'(7));
        send_request(OP_DELETE, key_t'(7));
        send_request(OP_DELETE, key_t'(7));
        send_request(OP_DELETE, key_t'(7));
    endtask

    // fill to capacity, push past it, then empty by deleting held keys
    task automatic test_fill_and_drain(input int rounds);
        repeat (rounds)
        begin
            while (heap_keys.size() < CAPACITY)
                send_request(OP_INSERT, pick_key());
            repeat ($urandom_range(1, 3))
                send_request(OP_INSERT, pick_key());
            while (heap_keys.size() != 0)
                send_request(OP_DELETE, pick_held_key());
            send_request(OP_DELETE, pick_key());
        end
    endtask

    // random mix, inserts favoured when nearly empty and deletes when nearly full
    task automatic test_random_mix(input int words);
        int insert_pct;
        repeat (words)
        begin
            insert_pct = (heap_keys.size() < 4) ? 75 : (heap_keys.size() > 12) ? 35 : 55;
            if ($urandom_range(0, 99) < insert_pct)
                send_request(OP_INSERT, pick_key());
            else if (heap_keys.size() != 0 && $urandom_range(0, 99) < 80)
                send_request(OP_DELETE, pick_held_key());
            else
                send_request(OP_DELETE, pick_key());
        end
    endtask

    // receiver holds off while the sender keeps offering words back to back
    task automatic test_backpressure();
        wait_for_drain();
        hold_token++;
        burst_left = 1000;
        repeat (20)
            send_request(1'($urandom_range(0, 1)), pick_key());
        burst_left = 0;
    endtask

    // sender pauses until the queue of results is empty
    task automatic test_drain_pause();
        repeat (10)
            send_request(1'($urandom_range(0, 1)), pick_key());
        wait_for_drain();
    endtask

    // test sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_delete();
        test_extreme_keys();
        test_duplicates();
        test_fill_and_drain(3);
        test_random_mix(120);
        test_backpressure();
        test_drain_pause();
        test_random_mix(130);
        wait_for_drain();
        repeat (SETTLE) @(posedge clk);
        $display("covered %0d requests and %0d results: %0d refused on a full heap, %0d misses",
                 requests_sent, results_seen, full_seen, miss_seen);
        $display("extreme and duplicate keys, fill to capacity, long receiver hold-off, drains");
        if (mismatches == 0)
            $display("max_heap_priority_queue_tb passed");
        else
            $display("max_heap_priority_queue_tb failed");
        $finish;
    end

endmodule

// ----- max_heap_priority_queue.f -----
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/max_heap_priority_queue.sv
test/max_heap_priority_queue_tb.sv
